>>> hdl/lsfa_pkg.sv
// Shared types and constants for the least-squares line fit accumulator.
// Used by the channel interfaces, the arithmetic unit and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lsfa_pkg;

  localparam int SIZE_SLOTS = 64;
  localparam int SLOT_W     = $clog2(SIZE_SLOTS);
  localparam int CNT_W      = $clog2(SIZE_SLOTS + 1);

  localparam int ARITH_W = 178;
  localparam int SQ_W    = 80;
  localparam int NI_W    = 104;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [16:0] R2_ONE    = 17'h10000;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_DIV
  } lsfa_op_e;

  typedef enum logic [1:0] {
    DQ_48,
    DQ_40,
    DQ_17
  } lsfa_dq_e;

  typedef struct packed {
    logic        mode;
    logic [23:0] size_bytes;
    logic [23:0] time_value;
  } lsfa_in_t;

  typedef struct packed {
    logic signed [47:0] slope_value;
    logic signed [39:0] intercept_value;
    logic [16:0]        r_squared;
    logic               fit_valid;
    logic               r_squared_valid;
    logic               three_sizes_seen;
    logic [15:0]        sample_count;
    logic               table_overflow;
  } lsfa_res_t;

  typedef struct packed {
    logic               start;
    lsfa_op_e           op;
    lsfa_dq_e           dq;
    logic [ARITH_W-1:0] a;
    logic [ARITH_W-1:0] b;
  } lsfa_req_t;

  typedef struct packed {
    logic               done;
    logic               neg;
    logic               ovf;
    logic [ARITH_W-1:0] res;
  } lsfa_rsp_t;

endpackage
`default_nettype wire

>>> hdl/lsfa_if.sv
// Valid/ready channel interfaces: sample input, fit result and configuration.
// Payload types come from lsfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface lsfa_in_if import lsfa_pkg::*; ();
  logic     valid;
  logic     ready;
  lsfa_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lsfa_res_if import lsfa_pkg::*; ();
  logic      valid;
  logic      ready;
  lsfa_res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lsfa_cfg_if ();
  logic valid;
  logic ready;
  logic payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/lsfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsfa_arith.sv
// Shared bit-serial arithmetic unit: multiply, add, magnitude subtract, divide.
// One wide adder serves every operation. Depends on lsfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsfa_arith import lsfa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  lsfa_req_t req_i,
  output lsfa_rsp_t rsp_o
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_CHK  = 2'd2;

  logic [1:0]         state_q;
  lsfa_op_e           op_q;
  logic [ARITH_W-1:0] acc_q;
  logic [ARITH_W-1:0] x_q;
  logic [ARITH_W-1:0] y_q;
  logic [47:0]        nlo_q;
  logic [47:0]        quo_q;
  logic [5:0]         cnt_q;
  lsfa_rsp_t          rsp_q;

  logic               sub;
  logic [ARITH_W-1:0] pa;
  logic [ARITH_W-1:0] pb;
  logic [ARITH_W:0]   sum;
  logic               carry;
  logic               unit_done;

  always_comb begin
    sub = 1'b1;
    pa  = x_q;
    pb  = y_q;
    if (state_q == U_RUN) begin
      unique case (op_q)
        OP_MUL: begin
          sub = 1'b0;
          pa  = acc_q;
          pb  = x_q;
        end
        OP_ADD: sub = 1'b0;
        OP_SUB: sub = 1'b1;
        OP_DIV: pa = {acc_q[ARITH_W-2:0], nlo_q[47]};
      endcase
    end else if (state_q == U_CHK) begin
      if (op_q == OP_DIV) begin
        pa = acc_q;
      end else begin
        pa = y_q;
        pb = x_q;
      end
    end
    sum   = {1'b0, pa} + {1'b0, (sub ? ~pb : pb)} + (ARITH_W + 1)'(sub);
    carry = sum[ARITH_W];
  end

  assign unit_done = ((state_q == U_RUN) &&
                      (((op_q == OP_MUL) && (y_q == '0)) || (op_q == OP_ADD) ||
                       ((op_q == OP_SUB) && carry) ||
                       ((op_q == OP_DIV) && (cnt_q == 6'd1)))) ||
                     ((state_q == U_CHK) && ((op_q != OP_DIV) || carry));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      op_q    <= OP_MUL;
      acc_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      nlo_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      rsp_q   <= '0;
    end else begin
      rsp_q.done <= unit_done;
      unique case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            op_q      <= req_i.op;
            x_q       <= req_i.a;
            y_q       <= req_i.b;
            quo_q     <= '0;
            rsp_q.ovf <= 1'b0;
            rsp_q.neg <= 1'b0;
            if (req_i.op == OP_DIV) begin
              state_q <= U_CHK;
              unique case (req_i.dq)
                DQ_48: begin
                  acc_q <= req_i.a >> 48;
                  nlo_q <= req_i.a[47:0];
                  cnt_q <= 6'd48;
                end
                DQ_40: begin
                  acc_q <= req_i.a >> 40;
                  nlo_q <= {req_i.a[39:0], 8'b0};
                  cnt_q <= 6'd40;
                end
                default: begin
                  acc_q <= req_i.a >> 17;
                  nlo_q <= {req_i.a[16:0], 31'b0};
                  cnt_q <= 6'd17;
                end
              endcase
            end else begin
              acc_q   <= (req_i.op == OP_MUL) ? '0 : req_i.a;
              state_q <= U_RUN;
            end
          end
        end
        U_RUN: begin
          unique case (op_q)
            OP_MUL: begin
              if (y_q == '0) begin
                rsp_q.res <= acc_q;
                state_q   <= U_IDLE;
              end else begin
                if (y_q[0]) begin
                  acc_q <= sum[ARITH_W-1:0];
                end
                x_q <= x_q << 1;
                y_q <= y_q >> 1;
              end
            end
            OP_ADD: begin
              rsp_q.res <= sum[ARITH_W-1:0];
              state_q   <= U_IDLE;
            end
            OP_SUB: begin
              if (carry) begin
                rsp_q.res <= sum[ARITH_W-1:0];
                state_q   <= U_IDLE;
              end else begin
                state_q <= U_CHK;
              end
            end
            OP_DIV: begin
              acc_q <= carry ? sum[ARITH_W-1:0] : pa;
              quo_q <= {quo_q[46:0], carry};
              nlo_q <= nlo_q << 1;
              cnt_q <= cnt_q - 6'd1;
              if (cnt_q == 6'd1) begin
                rsp_q.res <= ARITH_W'({quo_q[46:0], carry});
                state_q   <= U_IDLE;
              end
            end
          endcase
        end
        U_CHK: begin
          if (op_q == OP_DIV) begin
            if (carry) begin
              rsp_q.ovf <= 1'b1;
              rsp_q.res <= '0;
              state_q   <= U_IDLE;
            end else begin
              state_q <= U_RUN;
            end
          end else begin
            rsp_q.res <= sum[ARITH_W-1:0];
            rsp_q.neg <= 1'b1;
            state_q   <= U_IDLE;
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

>>> hdl/least_squares_line_fit_accumulator_unit.sv
// Top level of the least-squares line fit accumulator: size table, sums, sequencer.
// Depends on lsfa_pkg, lsfa_if, lsfa_ram and lsfa_arith.
//
// Usage:
//   in_chan_i  - one beat per sample (mode, size_bytes, time_value); mode set clears.
//   res_chan_o - one beat per input beat: slope, intercept, R squared and flags.
//   cfg_chan_i - writes regression_kind (0 average, 1 minimum per size); always ready.
//   Unless it clears or the table is empty, a beat first searches the table in
//   the RAM, with a read and a compare state per recorded size; then every
//   product, difference and rounded quotient runs bit-serially through the one
//   shared add/subtract unit in lsfa_arith (one multiplier bit or one quotient
//   bit a cycle). A clear, or fewer than two points, skips the fit.
//   One beat is in work at a time; in_chan_i.ready is high only while idle.
//   The result sits in an output register, so the next beat may enter while it
//   waits; a stalled receiver only blocks a later result from being written.
//   Reset clears sums, count, table fill and configuration; no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
module least_squares_line_fit_accumulator_unit import lsfa_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lsfa_in_if.sink   in_chan_i,
  lsfa_res_if.source res_chan_o,
  lsfa_cfg_if.sink  cfg_chan_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_PROD = 3'd4;
  localparam logic [2:0] S_FIT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [4:0] F_NSXX  = 5'd0;
  localparam logic [4:0] F_SXSX  = 5'd1;
  localparam logic [4:0] F_D     = 5'd2;
  localparam logic [4:0] F_NSXY  = 5'd3;
  localparam logic [4:0] F_SXSY  = 5'd4;
  localparam logic [4:0] F_NS    = 5'd5;
  localparam logic [4:0] F_SYSXX = 5'd6;
  localparam logic [4:0] F_SXSXY = 5'd7;
  localparam logic [4:0] F_NI    = 5'd8;
  localparam logic [4:0] F_NSYY  = 5'd9;
  localparam logic [4:0] F_SYSY  = 5'd10;
  localparam logic [4:0] F_E     = 5'd11;
  localparam logic [4:0] F_SNUM  = 5'd12;
  localparam logic [4:0] F_SDIV  = 5'd13;
  localparam logic [4:0] F_INUM  = 5'd14;
  localparam logic [4:0] F_IDIV  = 5'd15;
  localparam logic [4:0] F_NSNS  = 5'd16;
  localparam logic [4:0] F_DE    = 5'd17;
  localparam logic [4:0] F_RNUM  = 5'd18;
  localparam logic [4:0] F_RDIV  = 5'd19;
  localparam logic [4:0] F_MNUM  = 5'd20;
  localparam logic [4:0] F_MDIV  = 5'd21;

  logic [2:0]         state_q;
  logic [4:0]         step_q;
  logic               issued_q;
  logic               kind_q;
  logic               clr_q;
  logic [23:0]        x_q;
  logic [23:0]        y_q;
  logic [23:0]        old_q;
  logic               found_q;
  logic               rep_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [CNT_W-1:0]   ec_q;
  logic [15:0]        pc_q;
  logic [39:0]        sx_q;
  logic [39:0]        sy_q;
  logic [63:0]        sxy_q;
  logic [63:0]        sxx_q;
  logic [63:0]        syy_q;
  logic [ARITH_W-1:0] t1_q;
  logic [ARITH_W-1:0] t2_q;
  logic [SQ_W-1:0]    d_q;
  logic [SQ_W-1:0]    ns_q;
  logic [SQ_W-1:0]    e_q;
  logic [NI_W-1:0]    ni_q;
  logic               sn_q;
  logic               inn_q;
  logic               en_q;
  logic [47:0]        slope_q;
  logic [39:0]        icpt_q;
  logic [16:0]        r2_q;
  logic               fit_q;
  logic               r2ok_q;
  logic               ovf_q;
  lsfa_res_t          res_q;
  logic               out_valid_q;

  logic               in_acc;
  logic               room;
  logic               better;
  logic               dec_prod;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [47:0]        ram_rdata;
  lsfa_req_t          req;
  lsfa_rsp_t          rsp;
  logic [63:0]        prod;
  logic [47:0]        q48;
  logic [39:0]        q40;
  logic               big48;
  logic               big40;

  assign in_acc           = in_chan_i.valid && in_chan_i.ready;
  assign in_chan_i.ready  = (state_q == S_IDLE);
  assign cfg_chan_i.ready = 1'b1;
  assign res_chan_o.valid = out_valid_q;
  assign res_chan_o.payload = res_q;

  assign room   = (ec_q < CNT_W'(SIZE_SLOTS));
  assign better = (y_q < old_q);

  assign dec_prod = !clr_q &&
                    (kind_q ? (found_q ? better : (room && (pc_q < COUNT_MAX)))
                            : (pc_q < COUNT_MAX));

  always_comb begin
    ram_we = 1'b0;
    if (state_q == S_DEC && !clr_q) begin
      if (!kind_q) begin
        ram_we = (pc_q < COUNT_MAX) && (found_q ? better : room);
      end else begin
        ram_we = found_q ? better : (room && (pc_q < COUNT_MAX));
      end
    end
    ram_waddr = found_q ? idx_q : ec_q[SLOT_W-1:0];
  end

  lsfa_ram #(
    .WIDTH(48),
    .DEPTH(SIZE_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({x_q, y_q}),
    .re_i   (state_q == S_RD),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    req       = '0;
    req.op    = OP_MUL;
    req.dq    = DQ_48;
    req.start = !issued_q &&
                ((state_q == S_PROD) || (state_q == S_FIT && pc_q >= 16'd2));
    if (state_q == S_PROD) begin
      unique case (step_q[1:0])
        2'd0: begin
          req.a = ARITH_W'(x_q);
          req.b = ARITH_W'(y_q);
        end
        2'd1: begin
          req.a = ARITH_W'(x_q);
          req.b = rep_q ? ARITH_W'(old_q) : ARITH_W'(x_q);
        end
        2'd2: begin
          req.a = ARITH_W'(y_q);
          req.b = ARITH_W'(y_q);
        end
        default: begin
          req.a = ARITH_W'(old_q);
          req.b = ARITH_W'(old_q);
        end
      endcase
    end else begin
      unique case (step_q)
        F_NSXX: begin
          req.a = ARITH_W'(sxx_q);
          req.b = ARITH_W'(pc_q);
        end
        F_SXSX: begin
          req.a = ARITH_W'(sx_q);
          req.b = ARITH_W'(sx_q);
        end
        F_NSXY: begin
          req.a = ARITH_W'(sxy_q);
          req.b = ARITH_W'(pc_q);
        end
        F_SXSY: begin
          req.a = ARITH_W'(sy_q);
          req.b = ARITH_W'(sx_q);
        end
        F_SYSXX: begin
          req.a = ARITH_W'(sxx_q);
          req.b = ARITH_W'(sy_q);
        end
        F_SXSXY: begin
          req.a = ARITH_W'(sxy_q);
          req.b = ARITH_W'(sx_q);
        end
        F_NSYY: begin
          req.a = ARITH_W'(syy_q);
          req.b = ARITH_W'(pc_q);
        end
        F_SYSY: begin
          req.a = ARITH_W'(sy_q);
          req.b = ARITH_W'(sy_q);
        end
        F_D, F_NS, F_NI, F_E: begin
          req.op = OP_SUB;
          req.a  = t1_q;
          req.b  = t2_q;
        end
        F_SNUM: begin
          req.op = OP_ADD;
          req.a  = ARITH_W'({ns_q, 16'b0});
          req.b  = ARITH_W'(d_q >> 1);
        end
        F_SDIV: begin
          req.op = OP_DIV;
          req.dq = DQ_48;
          req.a  = t1_q;
          req.b  = ARITH_W'(d_q);
        end
        F_INUM: begin
          req.op = OP_ADD;
          req.a  = ARITH_W'(ni_q);
          req.b  = ARITH_W'(d_q >> 1);
        end
        F_IDIV: begin
          req.op = OP_DIV;
          req.dq = DQ_40;
          req.a  = t1_q;
          req.b  = ARITH_W'(d_q);
        end
        F_NSNS: begin
          req.a = ARITH_W'(ns_q);
          req.b = ARITH_W'(ns_q);
        end
        F_DE: begin
          req.a = ARITH_W'(d_q);
          req.b = ARITH_W'(e_q);
        end
        F_RNUM: begin
          req.op = OP_ADD;
          req.a  = {t1_q[ARITH_W-17:0], 16'b0};
          req.b  = t2_q >> 1;
        end
        F_RDIV: begin
          req.op = OP_DIV;
          req.dq = DQ_17;
          req.a  = t1_q;
          req.b  = t2_q;
        end
        F_MNUM: begin
          req.op = OP_ADD;
          req.a  = ARITH_W'(sy_q);
          req.b  = ARITH_W'(pc_q >> 1);
        end
        F_MDIV: begin
          req.op = OP_DIV;
          req.dq = DQ_40;
          req.a  = t1_q;
          req.b  = ARITH_W'(pc_q);
        end
        default: begin
          req.a = '0;
          req.b = '0;
        end
      endcase
    end
  end

  lsfa_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign prod  = rsp.res[63:0];
  assign q48   = rsp.res[47:0];
  assign q40   = rsp.res[39:0];
  assign big48 = rsp.ovf || q48[47];
  assign big40 = rsp.ovf || q40[39];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      issued_q    <= 1'b0;
      kind_q      <= 1'b0;
      clr_q       <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      old_q       <= '0;
      found_q     <= 1'b0;
      rep_q       <= 1'b0;
      idx_q       <= '0;
      ec_q        <= '0;
      pc_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      d_q         <= '0;
      ns_q        <= '0;
      e_q         <= '0;
      ni_q        <= '0;
      sn_q        <= 1'b0;
      inn_q       <= 1'b0;
      en_q        <= 1'b0;
      slope_q     <= '0;
      icpt_q      <= '0;
      r2_q        <= '0;
      fit_q       <= 1'b0;
      r2ok_q      <= 1'b0;
      ovf_q       <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_chan_i.valid && cfg_chan_i.ready) begin
        kind_q <= cfg_chan_i.payload;
      end
      if (state_q == S_OUT && (!out_valid_q || res_chan_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (res_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (req.start) begin
        issued_q <= 1'b1;
      end else if (rsp.done) begin
        issued_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            clr_q   <= in_chan_i.payload.mode;
            x_q     <= in_chan_i.payload.size_bytes;
            y_q     <= in_chan_i.payload.time_value;
            idx_q   <= '0;
            found_q <= 1'b0;
            slope_q <= '0;
            icpt_q  <= '0;
            r2_q    <= '0;
            fit_q   <= 1'b0;
            r2ok_q  <= 1'b0;
            ovf_q   <= 1'b0;
            state_q <= (in_chan_i.payload.mode || ec_q == '0) ? S_DEC : S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (ram_rdata[47:24] == x_q) begin
            found_q <= 1'b1;
            old_q   <= ram_rdata[23:0];
            state_q <= S_DEC;
          end else if (CNT_W'(idx_q) + CNT_W'(1) == ec_q) begin
            state_q <= S_DEC;
          end else begin
            idx_q   <= idx_q + SLOT_W'(1);
            state_q <= S_RD;
          end
        end
        S_DEC: begin
          rep_q   <= kind_q && found_q && better;
          step_q  <= '0;
          state_q <= dec_prod ? S_PROD : S_FIT;
          if (clr_q) begin
            ec_q  <= '0;
            pc_q  <= '0;
            sx_q  <= '0;
            sy_q  <= '0;
            sxy_q <= '0;
            sxx_q <= '0;
            syy_q <= '0;
          end else if (!kind_q) begin
            if (pc_q < COUNT_MAX) begin
              sx_q <= sx_q + 40'(x_q);
              sy_q <= sy_q + 40'(y_q);
              pc_q <= pc_q + 16'd1;
              if (!found_q) begin
                if (room) begin
                  ec_q <= ec_q + CNT_W'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
            end
          end else if (found_q) begin
            if (better) begin
              sy_q <= sy_q + 40'(y_q) - 40'(old_q);
            end
          end else if (!room) begin
            ovf_q <= 1'b1;
          end else if (pc_q < COUNT_MAX) begin
            ec_q <= ec_q + CNT_W'(1);
            sx_q <= sx_q + 40'(x_q);
            sy_q <= sy_q + 40'(y_q);
            pc_q <= pc_q + 16'd1;
          end
        end
        S_PROD: begin
          if (rsp.done) begin
            unique case (step_q[1:0])
              2'd0: sxy_q <= sxy_q + prod;
              2'd1: begin
                if (rep_q) begin
                  sxy_q <= sxy_q - prod;
                end else begin
                  sxx_q <= sxx_q + prod;
                end
              end
              2'd2: syy_q <= syy_q + prod;
              default: syy_q <= syy_q - prod;
            endcase
            if (step_q == (rep_q ? 5'd3 : 5'd2)) begin
              step_q  <= '0;
              state_q <= S_FIT;
            end else begin
              step_q <= step_q + 5'd1;
            end
          end
        end
        S_FIT: begin
          if (pc_q < 16'd2) begin
            state_q <= S_OUT;
          end else if (rsp.done) begin
            step_q <= (step_q == F_D && (rsp.neg || rsp.res == '0)) ? F_MNUM
                                                                     : step_q + 5'd1;
            unique case (step_q)
              F_SXSX, F_SXSY, F_SXSXY, F_SYSY, F_DE: t2_q <= rsp.res;
              F_D: d_q <= rsp.res[SQ_W-1:0];
              F_NS: begin
                ns_q <= rsp.res[SQ_W-1:0];
                sn_q <= rsp.neg;
              end
              F_NI: begin
                ni_q  <= rsp.res[NI_W-1:0];
                inn_q <= rsp.neg;
              end
              F_E: begin
                e_q  <= rsp.res[SQ_W-1:0];
                en_q <= rsp.neg;
              end
              F_SDIV: begin
                fit_q  <= 1'b1;
                r2ok_q <= 1'b1;
                if (sn_q) begin
                  slope_q <= big48 ? {1'b1, 47'b0} : (~q48 + 48'd1);
                end else begin
                  slope_q <= big48 ? {1'b0, {47{1'b1}}} : q48;
                end
              end
              F_IDIV: begin
                if (inn_q) begin
                  icpt_q <= big40 ? {1'b1, 39'b0} : (~q40 + 40'd1);
                end else begin
                  icpt_q <= big40 ? {1'b0, {39{1'b1}}} : q40;
                end
                if (en_q || e_q == '0) begin
                  r2_q    <= R2_ONE;
                  state_q <= S_OUT;
                end
              end
              F_RDIV: begin
                r2_q    <= (rsp.ovf || rsp.res[16:0] > R2_ONE) ? R2_ONE : rsp.res[16:0];
                state_q <= S_OUT;
              end
              F_MDIV: begin
                icpt_q  <= q40;
                state_q <= S_OUT;
              end
              default: t1_q <= rsp.res;
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_q || res_chan_o.ready) begin
            res_q.slope_value      <= slope_q;
            res_q.intercept_value  <= icpt_q;
            res_q.r_squared        <= r2_q;
            res_q.fit_valid        <= fit_q;
            res_q.r_squared_valid  <= r2ok_q;
            res_q.three_sizes_seen <= (ec_q >= CNT_W'(3));
            res_q.sample_count     <= pc_q;
            res_q.table_overflow   <= ovf_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= CNT_W'(SIZE_SLOTS))
    else $error("size table fill beyond its depth");

  a_fit_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.fit_valid |-> res_q.r_squared_valid && res_q.sample_count >= 16'd2)
    else $error("fit reported without its flags or points");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.fit_valid |->
      res_q.slope_value == '0 && res_q.r_squared == '0 && !res_q.r_squared_valid)
    else $error("degenerate fit carries nonzero slope or R squared");

  a_r2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.r_squared <= R2_ONE)
    else $error("R squared above one");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !issued_q)
    else $error("arithmetic operation outstanding while idle");

endmodule
`default_nettype wire
